// ----- hdl/fxa_pkg.sv -----
// ----------------------------------------------------------------------------
// fxa_pkg: shared types and codes for the fixed-point ALU
// Item layouts, opcodes, decoded command and operation kinds.
// ----------------------------------------------------------------------------
package fxa_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  localparam logic [4:0] OP_ADD     = 5'd0;
  localparam logic [4:0] OP_ADDINT  = 5'd1;
  localparam logic [4:0] OP_SUB     = 5'd2;
  localparam logic [4:0] OP_SUBINT  = 5'd3;
  localparam logic [4:0] OP_MUL     = 5'd4;
  localparam logic [4:0] OP_MULINT  = 5'd5;
  localparam logic [4:0] OP_DIV     = 5'd6;
  localparam logic [4:0] OP_DIVINT  = 5'd7;
  localparam logic [4:0] OP_NEG     = 5'd8;
  localparam logic [4:0] OP_FROMINT = 5'd9;
  localparam logic [4:0] OP_TOINT   = 5'd10;
  localparam logic [4:0] OP_EQ      = 5'd11;
  localparam logic [4:0] OP_NE      = 5'd12;
  localparam logic [4:0] OP_GT      = 5'd13;
  localparam logic [4:0] OP_GE      = 5'd14;
  localparam logic [4:0] OP_LT      = 5'd15;
  localparam logic [4:0] OP_LE      = 5'd16;
  localparam logic [4:0] OP_EQINT   = 5'd17;
  localparam logic [4:0] OP_NEINT   = 5'd18;
  localparam logic [4:0] OP_GTINT   = 5'd19;
  localparam logic [4:0] OP_GEINT   = 5'd20;
  localparam logic [4:0] OP_LTINT   = 5'd21;
  localparam logic [4:0] OP_LEINT   = 5'd22;

  localparam logic [3:0] K_NONE  = 4'd0;
  localparam logic [3:0] K_ADD   = 4'd1;
  localparam logic [3:0] K_NEG   = 4'd2;
  localparam logic [3:0] K_FROM  = 4'd3;
  localparam logic [3:0] K_TOINT = 4'd4;
  localparam logic [3:0] K_MUL   = 4'd5;
  localparam logic [3:0] K_MULI  = 4'd6;
  localparam logic [3:0] K_DIV   = 4'd7;
  localparam logic [3:0] K_DIVI  = 4'd8;
  localparam logic [3:0] K_CMP   = 4'd9;

  localparam logic [2:0] R_EQ = 3'd0;
  localparam logic [2:0] R_NE = 3'd1;
  localparam logic [2:0] R_GT = 3'd2;
  localparam logic [2:0] R_GE = 3'd3;
  localparam logic [2:0] R_LT = 3'd4;
  localparam logic [2:0] R_LE = 3'd5;

  typedef struct packed {
    logic [4:0]          opcode;
    logic signed [31:0]  operand_a;
    logic signed [31:0]  operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]  result_value;
    logic                compare_true;
    logic                divide_by_zero;
  } out_item_t;

  typedef struct packed {
    logic [3:0]          kind;
    logic                sub;
    logic                use_bsh;
    logic                lhs_sh;
    logic [2:0]          rel;
    logic signed [31:0]  a;
    logic signed [31:0]  b;
  } cmd_t;

endpackage

// ----- hdl/fxa_front.sv -----
// ----------------------------------------------------------------------------
// fxa_front: input stage
// Registers one item and decodes its opcode into an operation command.
// ----------------------------------------------------------------------------
module fxa_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  output logic             in_full,
  input  fxa_pkg::in_item_t in_item,
  output logic             cmd_valid,
  output fxa_pkg::cmd_t    cmd,
  input  logic             q_full
);
  import fxa_pkg::*;

  logic  v_r, v_nxt;
  cmd_t  cmd_r;
  cmd_t  dec;
  logic  acc, drain;

  always_comb begin
    dec         = '0;
    dec.a       = in_item.operand_a;
    dec.b       = in_item.operand_b;
    dec.kind    = K_NONE;
    case (in_item.opcode)
      OP_ADD:     dec.kind = K_ADD;
      OP_ADDINT:  begin dec.kind = K_ADD; dec.use_bsh = 1'b1; end
      OP_SUB:     begin dec.kind = K_ADD; dec.sub = 1'b1; end
      OP_SUBINT:  begin dec.kind = K_ADD; dec.sub = 1'b1; dec.use_bsh = 1'b1; end
      OP_MUL:     dec.kind = K_MUL;
      OP_MULINT:  dec.kind = K_MULI;
      OP_DIV:     dec.kind = K_DIV;
      OP_DIVINT:  dec.kind = K_DIVI;
      OP_NEG:     dec.kind = K_NEG;
      OP_FROMINT: dec.kind = K_FROM;
      OP_TOINT:   dec.kind = K_TOINT;
      OP_EQ:      begin dec.kind = K_CMP; dec.rel = R_EQ; end
      OP_NE:      begin dec.kind = K_CMP; dec.rel = R_NE; end
      OP_GT:      begin dec.kind = K_CMP; dec.rel = R_GT; end
      OP_GE:      begin dec.kind = K_CMP; dec.rel = R_GE; end
      OP_LT:      begin dec.kind = K_CMP; dec.rel = R_LT; end
      OP_LE:      begin dec.kind = K_CMP; dec.rel = R_LE; end
      OP_EQINT:   begin dec.kind = K_CMP; dec.rel = R_EQ; dec.lhs_sh = 1'b1; end
      OP_NEINT:   begin dec.kind = K_CMP; dec.rel = R_NE; dec.lhs_sh = 1'b1; end
      OP_GTINT:   begin dec.kind = K_CMP; dec.rel = R_GT; dec.use_bsh = 1'b1; end
      OP_GEINT:   begin dec.kind = K_CMP; dec.rel = R_GE; dec.use_bsh = 1'b1; end
      OP_LTINT:   begin dec.kind = K_CMP; dec.rel = R_LT; dec.use_bsh = 1'b1; end
      OP_LEINT:   begin dec.kind = K_CMP; dec.rel = R_LE; dec.use_bsh = 1'b1; end
      default:    dec.kind = K_NONE;
    endcase
  end

  assign in_full   = v_r && q_full;
  assign acc       = in_push && !in_full;
  assign drain     = v_r && !q_full;
  assign cmd_valid = v_r;
  assign cmd       = cmd_r;

  always_comb begin
    v_nxt = v_r;
    if (acc) begin
      v_nxt = 1'b1;
    end else if (drain) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_r <= dec;
    end
  end

endmodule

// ----- hdl/fxa_fifo.sv -----
// ----------------------------------------------------------------------------
// fxa_fifo: command queue
// Short register queue between the decode front and the execution back.
// ----------------------------------------------------------------------------
module fxa_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  fxa_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output fxa_pkg::cmd_t rd_data,
  output logic          empty
);
  import fxa_pkg::*;

  cmd_t               mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_wr, do_rd;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_wr ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end

endmodule

// ----- hdl/fxa_back.sv -----
// ----------------------------------------------------------------------------
// fxa_back: execution pipeline
// Operand stage with multiplier, one restoring divide step per stage,
// and a final select stage that also serves as the output register.
// ----------------------------------------------------------------------------
module fxa_back #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  fxa_pkg::cmd_t      q_data,
  output logic               q_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output fxa_pkg::out_item_t out_item
);
  import fxa_pkg::*;

  localparam int unsigned DW = 32 + FRACTION_BITS;
  localparam int unsigned NS = DW + 1;

  typedef struct packed {
    logic [3:0]          kind;
    logic signed [31:0]  res;
    logic signed [63:0]  prod;
    logic                negq;
    logic                dz;
    logic                cmp;
    logic [31:0]         rem;
    logic [DW-1:0]       dvd;
    logic [31:0]         dsr;
  } bst_t;

  function automatic bst_t div_step(input bst_t s);
    bst_t        t;
    logic [32:0] r2;
    logic [32:0] df;
    t  = s;
    r2 = {s.rem, s.dvd[DW-1]};
    df = r2 - {1'b0, s.dsr};
    if (!df[32]) begin
      t.rem = df[31:0];
      t.dvd = {s.dvd[DW-2:0], 1'b1};
    end else begin
      t.rem = r2[31:0];
      t.dvd = {s.dvd[DW-2:0], 1'b0};
    end
    return t;
  endfunction

  logic              adv;
  logic [NS:0]       v_r;
  bst_t              st_r [NS];
  bst_t              s0;
  out_item_t         out_r, fin;

  logic signed [31:0] a, b, bsh, rhs, lhs, crhs;
  logic [31:0]        abs_a, abs_b;
  logic               cmp;
  logic signed [63:0] prod_sh;
  logic [31:0]        q;

  assign adv       = !v_r[NS] || out_pop;
  assign q_pop     = adv && !q_empty;
  assign out_empty = !v_r[NS];
  assign out_item  = out_r;

  always_comb begin
    a     = q_data.a;
    b     = q_data.b;
    bsh   = b <<< FRACTION_BITS;
    rhs   = q_data.use_bsh ? bsh : b;
    lhs   = q_data.lhs_sh ? (a >>> FRACTION_BITS) : a;
    crhs  = rhs;
    abs_a = a[31] ? 32'(-a) : a;
    abs_b = b[31] ? 32'(-b) : b;
    case (q_data.rel)
      R_EQ:    cmp = (lhs == crhs);
      R_NE:    cmp = (lhs != crhs);
      R_GT:    cmp = (lhs > crhs);
      R_GE:    cmp = (lhs >= crhs);
      R_LT:    cmp = (lhs < crhs);
      R_LE:    cmp = (lhs <= crhs);
      default: cmp = 1'b0;
    endcase
    s0      = '0;
    s0.kind = q_data.kind;
    s0.prod = a * b;
    s0.negq = a[31] ^ b[31];
    s0.dz   = (b == 0);
    s0.dsr  = abs_b;
    s0.dvd  = (q_data.kind == K_DIV) ? {abs_a, {FRACTION_BITS{1'b0}}}
                                     : DW'(abs_a);
    case (q_data.kind)
      K_ADD:   s0.res = q_data.sub ? (a - rhs) : (a + rhs);
      K_NEG:   s0.res = -a;
      K_FROM:  s0.res = bsh;
      K_TOINT: s0.res = a >>> FRACTION_BITS;
      K_CMP:   s0.cmp = cmp;
      default: s0.res = '0;
    endcase
  end

  always_comb begin
    prod_sh = st_r[NS-1].prod >>> FRACTION_BITS;
    q       = st_r[NS-1].dvd[31:0];
    fin     = '0;
    case (st_r[NS-1].kind)
      K_MUL:  fin.result_value = prod_sh[31:0];
      K_MULI: fin.result_value = st_r[NS-1].prod[31:0];
      K_DIV, K_DIVI: begin
        if (st_r[NS-1].dz) begin
          fin.divide_by_zero = 1'b1;
        end else begin
          fin.result_value = st_r[NS-1].negq ? 32'(-q) : q;
        end
      end
      K_CMP:   fin.compare_true = st_r[NS-1].cmp;
      default: fin.result_value = st_r[NS-1].res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NS-1:0], !q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0] <= s0;
      out_r   <= fin;
    end
  end

  for (genvar i = 1; i < NS; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[i] <= div_step(st_r[i-1]);
      end
    end
  end

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NS] && !out_pop) |=> (v_r[NS] && $stable(out_r)))
    else $error("output item changed while stalled");
  a_dz: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NS] && out_r.divide_by_zero) |-> (out_r.result_value == 0 && !out_r.compare_true))
    else $error("divide by zero item carries a value");
  a_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NS] && out_r.compare_true) |-> (out_r.result_value == 0))
    else $error("compare item carries a value");
`endif

endmodule

// ----- hdl/q16_16_fixed_point_alu.sv -----
// ----------------------------------------------------------------------------
// q16_16_fixed_point_alu: signed fixed-point ALU
// Format: Q16.16 with the default FRACTION_BITS.
// Throughput: one item per cycle while out_pop drains the output; the divider is one quotient bit per stage.
// Reset: synchronous active-low rst_n empties front register, queue and pipe.
// ----------------------------------------------------------------------------
module q16_16_fixed_point_alu #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  fxa_pkg::in_item_t  in_item,
  output logic               out_empty,
  input  logic               out_pop,
  output fxa_pkg::out_item_t out_item
);
  import fxa_pkg::*;

  logic  f_valid, q_full, q_empty, q_pop;
  cmd_t  f_cmd, q_data;

  fxa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_item   (in_item),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .q_full    (q_full)
  );

  fxa_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (f_valid),
    .wr_data (f_cmd),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  fxa_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench for the Q16.16 fixed-point ALU
// Drives opcode/operand items through the push/full port in random bursts,
// predicts each result in 64-bit arithmetic and checks the popped items in
// order while the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;
  import fxa_pkg::*;

  localparam int FB = 16;
  localparam int LATENCY = FB + 36;
  localparam int WD_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_item_t in_item = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_item_t out_item;

  in_item_t pending_q[$];
  out_item_t alu_expect_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 1'b0;
  bit hold_off = 1'b0;
  bit in_taken = 1'b0;
  int gap_left = 0;
  int burst_left = 0;
  int pop_phase = 0;

  q16_16_fixed_point_alu #(.FRACTION_BITS(FB)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );

  always #5 clk = ~clk;

  function automatic longint asr(longint v);
    return v >>> FB;
  endfunction

  function automatic out_item_t alu_predict(in_item_t it);
    out_item_t r;
    longint a, b, bsh, res;
    logic [31:0] bsh32;
    a = longint'(it.operand_a);
    b = longint'(it.operand_b);
    bsh32 = it.operand_b <<< FB;
    bsh = longint'($signed(bsh32));
    res = 0;
    r = '0;
    case (it.opcode)
      OP_ADD:     res = a + b;
      OP_ADDINT:  res = a + bsh;
      OP_SUB:     res = a - b;
      OP_SUBINT:  res = a - bsh;
      OP_MUL:     res = asr(a * b);
      OP_MULINT:  res = a * b;
      OP_DIV:     if (b == 0) r.divide_by_zero = 1'b1; else res = (a <<< FB) / b;
      OP_DIVINT:  if (b == 0) r.divide_by_zero = 1'b1; else res = a / b;
      OP_NEG:     res = -a;
      OP_FROMINT: res = bsh;
      OP_TOINT:   res = asr(a);
      OP_EQ:      r.compare_true = (a == b);
      OP_NE:      r.compare_true = (a != b);
      OP_GT:      r.compare_true = (a > b);
      OP_GE:      r.compare_true = (a >= b);
      OP_LT:      r.compare_true = (a < b);
      OP_LE:      r.compare_true = (a <= b);
      OP_EQINT:   r.compare_true = (asr(a) == b);
      OP_NEINT:   r.compare_true = (asr(a) != b);
      OP_GTINT:   r.compare_true = (a > bsh);
      OP_GEINT:   r.compare_true = (a >= bsh);
      OP_LTINT:   r.compare_true = (a < bsh);
      OP_LEINT:   r.compare_true = (a <= bsh);
      default: ;
    endcase
    r.result_value = res[31:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 8)) - 4);
      3: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
      4: return {16'($signed($urandom_range(0, 64)) - 32), 16'h0000};
      5: return {16'($signed($urandom_range(0, 512)) - 256), 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic add_item(logic [4:0] op, logic [31:0] a, logic [31:0] b);
    in_item_t it;
    it.opcode = op;
    it.operand_a = a;
    it.operand_b = b;
    pending_q.push_back(it);
  endtask

  // driver
  always @(negedge clk) begin
    if (in_taken) begin
      alu_expect_q.push_back(alu_predict(in_item));
      void'(pending_q.pop_front());
    end
    if (!rst_n || hold_off || pending_q.size() == 0) begin
      in_push <= 1'b0;
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      in_push <= 1'b0;
    end else begin
      in_push <= 1'b1;
      in_item <= pending_q[0];
      if (burst_left == 0) begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
    pop_phase <= pop_phase + 1;
    out_pop <= rst_n && ((pop_phase % 97) < 60 || (pop_phase % 7) == 3 ||
                         $urandom_range(0, 3) == 0);
  end

  // monitor
  always @(posedge clk) begin
    in_taken <= rst_n && in_push && !in_full;
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_pop && !out_empty) begin
        if (alu_expect_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_item);
          errors <= errors + 1;
        end else if (out_item !== alu_expect_q[0]) begin
          $display("%0t: mismatch expected val=%h cmp=%b dz=%b actual val=%h cmp=%b dz=%b",
                   $time, alu_expect_q[0].result_value, alu_expect_q[0].compare_true,
                   alu_expect_q[0].divide_by_zero, out_item.result_value,
                   out_item.compare_true, out_item.divide_by_zero);
          errors <= errors + 1;
          void'(alu_expect_q.pop_front());
        end else begin
          void'(alu_expect_q.pop_front());
        end
      end
      if (idle_cycles > WD_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [4:0] op;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // directed: every opcode, extremes, divide by zero, overflowing divides
    for (int i = 0; i < 24; i++) begin
      add_item(5'(i), 32'h0003_8000, 32'hfffe_4000);
    end
    add_item(OP_DIVINT, 32'h8000_0000, 32'hffff_ffff);
    add_item(OP_DIV, 32'h7fff_ffff, 32'h0000_0001);
    add_item(OP_DIV, 32'h1234_5678, 32'h0);
    add_item(OP_DIVINT, 32'h8000_0000, 32'h0);
    add_item(OP_MUL, 32'h8000_0000, 32'h8000_0000);
    add_item(OP_TOINT, 32'hffff_8000, 32'h0);
    add_item(OP_EQINT, 32'hffff_8000, 32'hffff_ffff);
    add_item(OP_GEINT, 32'h8000_0000, 32'h0000_8000);
    add_item(5'd31, 32'hffff_ffff, 32'hffff_ffff);
    wait (pending_q.size() == 0 && alu_expect_q.size() == 0);
    hold_off = 1'b0;
    for (int i = 0; i < 850; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(23, 31))
                                        : 5'($urandom_range(0, 22));
      add_item(op, rand_operand(), rand_operand());
      if (i == 400) begin
        wait (pending_q.size() == 0);
        hold_off = 1'b1;
        wait (alu_expect_q.size() == 0);
        hold_off = 1'b0;
      end
    end
    wait (pending_q.size() == 0 && !in_push);
    wait (alu_expect_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && alu_expect_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
